// ===== rtl/first_fit_heap_allocator_defines.svh =====
// Assertion macros for the allocator RTL
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle property, checked out of reset
`define FFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ffa_pkg.sv =====
// Types and constants of the first-fit heap allocator
package ffa_pkg;

	localparam int HEAP_BYTES = 1048576;
	localparam int HDR_BYTES  = 40;
	localparam int ALIGN      = 8;
	localparam int MAX_BLOCKS = 1024;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int LINK_W = IDX_W + 1;
	localparam int ADDR_W = 20;
	localparam int LEN_W  = 20;
	localparam int REQ_W  = 21;
	localparam int SUM_W  = 22;

	localparam logic [LINK_W-1:0] NONE = LINK_W'(MAX_BLOCKS);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_NULL    = 3'd1,
		STS_NO_FIT  = 3'd2,
		STS_BAD_PTR = 3'd3,
		STS_DBL_FREE = 3'd4
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  length;
		logic              is_free;
		logic [LINK_W-1:0] next;
	} rec_t;

	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
		logic              rec_we;
		logic [IDX_W-1:0]  rec_addr;
		rec_t              rec_data;
		logic              prev_we;
		logic [IDX_W-1:0]  prev_addr;
		logic [LINK_W-1:0] prev_data;
		logic              link_we;
		logic [IDX_W-1:0]  link_addr;
		logic [LINK_W-1:0] link_data;
	} mem_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] a;
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] c;
		logic             sub;
		logic             hdr;
	} alu_in_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             ge_a;
		logic             ge_sum;
		logic             eq;
	} alu_out_t;

endpackage

// ===== rtl/ffa_alu.sv =====
// Shared add/subtract and compare unit
module ffa_alu
	import ffa_pkg::*;
(
	input  alu_in_t  alu_in,
	output alu_out_t alu_out
);

	logic [SUM_W-1:0] hdr_add;
	logic [SUM_W-1:0] sum;

	assign hdr_add = alu_in.hdr ? SUM_W'(HDR_BYTES) : '0;

	always_comb begin
		if (alu_in.sub) begin
			sum = alu_in.a - alu_in.b - hdr_add;
		end else begin
			sum = alu_in.a + alu_in.b + hdr_add;
		end
	end

	assign alu_out.sum    = sum;
	assign alu_out.ge_a   = alu_in.c >= alu_in.a;
	assign alu_out.ge_sum = alu_in.c >= sum;
	assign alu_out.eq     = alu_in.c == sum;

endmodule

// ===== rtl/ffa_store.sv =====
// Block table memories: records, back links, spare chain
module ffa_store
	import ffa_pkg::*;
(
	input  logic              clk,
	input  mem_req_t          mem_req,
	output rec_t              rd_rec,
	output logic [LINK_W-1:0] rd_prev,
	output logic [LINK_W-1:0] rd_link
);

	rec_t              rec_mem  [MAX_BLOCKS];
	logic [LINK_W-1:0] prev_mem [MAX_BLOCKS];
	logic [LINK_W-1:0] link_mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (mem_req.rec_we) begin
			rec_mem[mem_req.rec_addr] <= mem_req.rec_data;
		end
		if (mem_req.rd_en) begin
			rd_rec <= rec_mem[mem_req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.prev_we) begin
			prev_mem[mem_req.prev_addr] <= mem_req.prev_data;
		end
		if (mem_req.rd_en) begin
			rd_prev <= prev_mem[mem_req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.link_we) begin
			link_mem[mem_req.link_addr] <= mem_req.link_data;
		end
		if (mem_req.rd_en) begin
			rd_link <= link_mem[mem_req.rd_addr];
		end
	end

endmodule

// ===== rtl/ffa_ctrl.sv =====
// Sequencer: list walk, split, merge and result register
`include "first_fit_heap_allocator_defines.svh"
module ffa_ctrl
	import ffa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_op,
	input  logic [REQ_W-1:0]  in_req,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] out_addr,
	output logic [LEN_W-1:0]  out_len,
	output logic [2:0]        out_status,
	output mem_req_t          mem_req,
	input  rec_t              rd_rec,
	input  logic [LINK_W-1:0] rd_prev,
	input  logic [LINK_W-1:0] rd_link,
	output alu_in_t           alu_in,
	input  alu_out_t          alu_out
);

	typedef enum logic [12:0] {
		S_INIT  = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_RD    = 13'b0000000000100,
		S_CHK   = 13'b0000000001000,
		S_SPA   = 13'b0000000010000,
		S_SPB   = 13'b0000000100000,
		S_SPC   = 13'b0000001000000,
		S_NXRD  = 13'b0000010000000,
		S_NXCHK = 13'b0000100000000,
		S_WRB   = 13'b0001000000000,
		S_PVRD  = 13'b0010000000000,
		S_PVCHK = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [SUM_W-1:0]  n_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  cur_q;
	rec_t              rec_q;
	logic [LINK_W-1:0] prev_q;
	logic [IDX_W-1:0]  nb_q;
	logic [ADDR_W-1:0] nstart_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] fresh_q;
	status_t           sts_q;
	logic              grant_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [LEN_W-1:0]  out_len_q;
	status_t           out_sts_q;
	logic              load;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_len    = out_len_q;
	assign out_status = out_sts_q;
	assign load       = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// operand select for the shared unit
	always_comb begin
		alu_in = '0;
		unique case (state_q)
			S_IDLE: begin
				alu_in.a = SUM_W'(in_req);
				alu_in.b = SUM_W'(ALIGN - 1);
			end
			S_CHK: begin
				if (op_q == OP_ALLOC) begin
					alu_in.a   = n_q;
					alu_in.b   = SUM_W'(ALIGN);
					alu_in.hdr = 1'b1;
					alu_in.c   = SUM_W'(rd_rec.length);
				end else begin
					alu_in.a   = SUM_W'(rd_rec.start);
					alu_in.hdr = 1'b1;
					alu_in.c   = SUM_W'(addr_q);
				end
			end
			S_SPA: begin
				alu_in.a   = SUM_W'(rec_q.start);
				alu_in.b   = n_q;
				alu_in.hdr = 1'b1;
			end
			S_SPB: begin
				alu_in.a   = SUM_W'(rec_q.length);
				alu_in.b   = n_q;
				alu_in.sub = 1'b1;
				alu_in.hdr = 1'b1;
			end
			S_NXCHK: begin
				alu_in.a   = SUM_W'(rec_q.length);
				alu_in.b   = SUM_W'(rd_rec.length);
				alu_in.hdr = 1'b1;
			end
			S_PVCHK: begin
				alu_in.a   = SUM_W'(rd_rec.length);
				alu_in.b   = SUM_W'(rec_q.length);
				alu_in.hdr = 1'b1;
			end
			S_DONE: begin
				alu_in.a   = SUM_W'(rec_q.start);
				alu_in.hdr = 1'b1;
			end
			default: begin
				alu_in = '0;
			end
		endcase
	end

	// memory requests and next state
	always_comb begin
		mem_req = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				mem_req.rec_we         = 1'b1;
				mem_req.rec_addr       = '0;
				mem_req.rec_data.start = '0;
				mem_req.rec_data.length = LEN_W'(HEAP_BYTES - HDR_BYTES);
				mem_req.rec_data.is_free = 1'b1;
				mem_req.rec_data.next  = NONE;
				mem_req.prev_we        = 1'b1;
				mem_req.prev_addr      = '0;
				mem_req.prev_data      = NONE;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_ALLOC) begin
						state_d = (in_req == '0) ? S_DONE : S_RD;
					end else begin
						state_d = (in_addr == '0) ? S_DONE : S_RD;
					end
				end
			end
			S_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = cur_q;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (op_q == OP_ALLOC) begin
					if (rd_rec.is_free && alu_out.ge_a) begin
						if (alu_out.ge_sum && head_q != NONE) begin
							state_d = S_SPA;
						end else begin
							mem_req.rec_we   = 1'b1;
							mem_req.rec_addr = cur_q;
							mem_req.rec_data = rd_rec;
							mem_req.rec_data.is_free = 1'b0;
							state_d = S_DONE;
						end
					end else if (rd_rec.next == NONE) begin
						state_d = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end else begin
					if (alu_out.eq) begin
						if (rd_rec.is_free) begin
							state_d = S_DONE;
						end else if (rd_rec.next != NONE) begin
							state_d = S_NXRD;
						end else begin
							state_d = S_WRB;
						end
					end else if (rd_rec.next == NONE) begin
						state_d = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_SPA: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = head_q[IDX_W-1:0];
				state_d = S_SPB;
			end
			S_SPB: begin
				mem_req.rec_we   = 1'b1;
				mem_req.rec_addr = nb_q;
				mem_req.rec_data.start   = nstart_q;
				mem_req.rec_data.length  = alu_out.sum[LEN_W-1:0];
				mem_req.rec_data.is_free = 1'b1;
				mem_req.rec_data.next    = rec_q.next;
				mem_req.prev_we   = 1'b1;
				mem_req.prev_addr = nb_q;
				mem_req.prev_data = {1'b0, cur_q};
				state_d = S_SPC;
			end
			S_SPC: begin
				mem_req.rec_we   = 1'b1;
				mem_req.rec_addr = cur_q;
				mem_req.rec_data.start   = rec_q.start;
				mem_req.rec_data.length  = n_q[LEN_W-1:0];
				mem_req.rec_data.is_free = 1'b0;
				mem_req.rec_data.next    = {1'b0, nb_q};
				if (rec_q.next != NONE) begin
					mem_req.prev_we   = 1'b1;
					mem_req.prev_addr = rec_q.next[IDX_W-1:0];
					mem_req.prev_data = {1'b0, nb_q};
				end
				state_d = S_DONE;
			end
			S_NXRD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = rec_q.next[IDX_W-1:0];
				state_d = S_NXCHK;
			end
			S_NXCHK: begin
				if (rd_rec.is_free) begin
					if (rd_rec.next != NONE) begin
						mem_req.prev_we   = 1'b1;
						mem_req.prev_addr = rd_rec.next[IDX_W-1:0];
						mem_req.prev_data = {1'b0, cur_q};
					end
					mem_req.link_we   = 1'b1;
					mem_req.link_addr = rec_q.next[IDX_W-1:0];
					mem_req.link_data = head_q;
				end
				state_d = S_WRB;
			end
			S_WRB: begin
				mem_req.rec_we   = 1'b1;
				mem_req.rec_addr = cur_q;
				mem_req.rec_data = rec_q;
				mem_req.rec_data.is_free = 1'b1;
				state_d = (prev_q != NONE) ? S_PVRD : S_DONE;
			end
			S_PVRD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = prev_q[IDX_W-1:0];
				state_d = S_PVCHK;
			end
			S_PVCHK: begin
				if (rd_rec.is_free) begin
					mem_req.rec_we   = 1'b1;
					mem_req.rec_addr = prev_q[IDX_W-1:0];
					mem_req.rec_data.start   = rd_rec.start;
					mem_req.rec_data.length  = alu_out.sum[LEN_W-1:0];
					mem_req.rec_data.is_free = 1'b1;
					mem_req.rec_data.next    = rec_q.next;
					if (rec_q.next != NONE) begin
						mem_req.prev_we   = 1'b1;
						mem_req.prev_addr = rec_q.next[IDX_W-1:0];
						mem_req.prev_data = prev_q;
					end
					mem_req.link_we   = 1'b1;
					mem_req.link_addr = cur_q;
					mem_req.link_data = head_q;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			head_q      <= LINK_W'(1);
			fresh_q     <= LINK_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SPB: begin
					if (head_q == fresh_q) begin
						head_q  <= fresh_q + LINK_W'(1);
						fresh_q <= fresh_q + LINK_W'(1);
					end else begin
						head_q <= rd_link;
					end
				end
				S_NXCHK: begin
					if (rd_rec.is_free) begin
						head_q <= rec_q.next;
					end
				end
				S_PVCHK: begin
					if (rd_rec.is_free) begin
						head_q <= {1'b0, cur_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q    <= op_t'(in_op);
				n_q     <= SUM_W'((alu_out.sum / ALIGN) * ALIGN);
				addr_q  <= in_addr;
				cur_q   <= '0;
				grant_q <= 1'b0;
				sts_q   <= STS_NULL;
			end
			S_CHK: begin
				rec_q  <= rd_rec;
				prev_q <= rd_prev;
				if (op_q == OP_ALLOC) begin
					if (rd_rec.is_free && alu_out.ge_a) begin
						grant_q <= 1'b1;
						sts_q   <= STS_OK;
					end else begin
						cur_q <= rd_rec.next[IDX_W-1:0];
						sts_q <= STS_NO_FIT;
					end
				end else begin
					if (alu_out.eq) begin
						sts_q <= rd_rec.is_free ? STS_DBL_FREE : STS_OK;
					end else begin
						cur_q <= rd_rec.next[IDX_W-1:0];
						sts_q <= STS_BAD_PTR;
					end
				end
			end
			S_SPA: begin
				nstart_q <= alu_out.sum[ADDR_W-1:0];
				nb_q     <= head_q[IDX_W-1:0];
			end
			S_SPC: begin
				rec_q.length <= n_q[LEN_W-1:0];
			end
			S_NXCHK: begin
				if (rd_rec.is_free) begin
					rec_q.length <= alu_out.sum[LEN_W-1:0];
					rec_q.next   <= rd_rec.next;
				end
			end
			S_DONE: begin
				if (load) begin
					out_addr_q <= grant_q ? alu_out.sum[ADDR_W-1:0] : '0;
					out_len_q  <= grant_q ? rec_q.length : '0;
					out_sts_q  <= sts_q;
				end
			end
			default: begin
			end
		endcase
	end

	`FFA_ASSERT(a_head_fresh, head_q <= fresh_q, "spare head beyond fresh mark")
	`FFA_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "request overlap")
	`FFA_ASSERT(a_fail_zero, !(out_valid_q && out_sts_q != STS_OK && op_q == OP_ALLOC) || (out_addr_q == '0 && out_len_q == '0), "failed allocate carries data")

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator
//
//  channel  dir  tdata                                  tuser
//  s_*      in   [20:0] request_bytes [40:21] free_addr  [0] operation
//  m_*      out  [19:0] data_address [39:20] granted     [2:0] status
//
// Between one accept and the next, each block walked takes a record read
// and its check. After reset the sequencer sets up the first block before
// s_tready rises.
// A result waits in the output register; the next request is taken once
// the sequencer is idle, so a stalled m_tready holds only the finish step.
module first_fit_heap_allocator
	import ffa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // request_bytes, free_address, unused pad
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // data_address, granted_bytes
	output logic [2:0]  m_tuser    // status
);

	mem_req_t          mem_req;
	rec_t              rd_rec;
	logic [LINK_W-1:0] rd_prev;
	logic [LINK_W-1:0] rd_link;
	alu_in_t           alu_in;
	alu_out_t          alu_out;
	logic [ADDR_W-1:0] out_addr;
	logic [LEN_W-1:0]  out_len;

	ffa_alu u_alu (
		.alu_in  (alu_in),
		.alu_out (alu_out)
	);

	ffa_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_rec  (rd_rec),
		.rd_prev (rd_prev),
		.rd_link (rd_link)
	);

	ffa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_req     (s_tdata[20:0]),
		.in_addr    (s_tdata[40:21]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_addr   (out_addr),
		.out_len    (out_len),
		.out_status (m_tuser),
		.mem_req    (mem_req),
		.rd_rec     (rd_rec),
		.rd_prev    (rd_prev),
		.rd_link    (rd_link),
		.alu_in     (alu_in),
		.alu_out    (alu_out)
	);

	assign m_tdata = {out_len, out_addr};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the first-fit heap allocator
module tb;
	import ffa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		bit                pause;
		op_t               op;
		logic [REQ_W-1:0]  req;
		logic [ADDR_W-1:0] addr;
	} heap_req_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		status_t           st;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;

	first_fit_heap_allocator u_top (.*);

	always #5 clk = ~clk;

	// heap shadow
	logic [ADDR_W-1:0] sh_start [MAX_BLOCKS];
	logic [LEN_W-1:0]  sh_len   [MAX_BLOCKS];
	bit                sh_free  [MAX_BLOCKS];
	int unsigned       sh_next  [MAX_BLOCKS];
	int unsigned       sh_prev  [MAX_BLOCKS];
	int unsigned       sh_spare [MAX_BLOCKS];
	int unsigned       spare_head;

	heap_req_t   pending_q [$];
	grant_t      grant_q [$];
	logic [19:0] live_q [$];
	logic [19:0] freed_q [$];
	int          n_fail = 0;
	int          n_sent = 0;
	int          n_done = 0;
	int          idle_cycles = 0;
	bit          no_gaps = 1'b0;

	function automatic void release_entry(int unsigned e);
		sh_spare[e] = spare_head;
		spare_head = e;
		sh_start[e] = '0;
		sh_len[e] = '0;
		sh_free[e] = 1'b0;
		sh_next[e] = MAX_BLOCKS;
		sh_prev[e] = MAX_BLOCKS;
	endfunction

	function automatic grant_t heap_alloc(logic [REQ_W-1:0] req);
		grant_t      g;
		int unsigned n, b, nb;
		g = '{addr: '0, len: '0, st: STS_NO_FIT};
		if (req == 0) begin
			g.st = STS_NULL;
			return g;
		end
		n = ((int'(req) + ALIGN - 1) / ALIGN) * ALIGN;
		b = 0;
		for (int s = 0; s < MAX_BLOCKS && b < MAX_BLOCKS; s++) begin
			if (sh_free[b] && sh_len[b] >= n) begin
				if (sh_len[b] >= n + HDR_BYTES + ALIGN && spare_head < MAX_BLOCKS) begin
					nb = spare_head;
					spare_head = sh_spare[nb];
					sh_start[nb] = ADDR_W'(sh_start[b] + HDR_BYTES + n);
					sh_len[nb] = LEN_W'(sh_len[b] - n - HDR_BYTES);
					sh_free[nb] = 1'b1;
					sh_next[nb] = sh_next[b];
					sh_prev[nb] = b;
					if (sh_next[b] < MAX_BLOCKS)
						sh_prev[sh_next[b]] = nb;
					sh_next[b] = nb;
					sh_len[b] = LEN_W'(n);
				end
				sh_free[b] = 1'b0;
				g.addr = ADDR_W'(sh_start[b] + HDR_BYTES);
				g.len = sh_len[b];
				g.st = STS_OK;
				return g;
			end
			b = sh_next[b];
		end
		return g;
	endfunction

	function automatic grant_t heap_free(logic [ADDR_W-1:0] addr);
		grant_t      g;
		int unsigned b, nx, pv;
		int          s;
		g = '{addr: '0, len: '0, st: STS_OK};
		if (addr == 0) begin
			g.st = STS_NULL;
			return g;
		end
		b = 0;
		for (s = 0; s < MAX_BLOCKS && b < MAX_BLOCKS; s++) begin
			if (sh_start[b] + HDR_BYTES == int'(addr))
				break;
			b = sh_next[b];
		end
		if (b >= MAX_BLOCKS || s >= MAX_BLOCKS) begin
			g.st = STS_BAD_PTR;
			return g;
		end
		if (sh_free[b]) begin
			g.st = STS_DBL_FREE;
			return g;
		end
		sh_free[b] = 1'b1;
		nx = sh_next[b];
		if (nx < MAX_BLOCKS && sh_free[nx]) begin
			sh_len[b] = LEN_W'(sh_len[b] + HDR_BYTES + sh_len[nx]);
			sh_next[b] = sh_next[nx];
			if (sh_next[b] < MAX_BLOCKS)
				sh_prev[sh_next[b]] = b;
			release_entry(nx);
		end
		pv = sh_prev[b];
		if (pv < MAX_BLOCKS && sh_free[pv]) begin
			sh_len[pv] = LEN_W'(sh_len[pv] + HDR_BYTES + sh_len[b]);
			sh_next[pv] = sh_next[b];
			if (sh_next[b] < MAX_BLOCKS)
				sh_prev[sh_next[b]] = pv;
			release_entry(b);
		end
		return g;
	endfunction

	task automatic queue_request(op_t op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr);
		grant_t g;
		if (op == OP_ALLOC)
			g = heap_alloc(req);
		else
			g = heap_free(addr);
		if (op == OP_ALLOC && g.st == STS_OK)
			live_q.push_back(g.addr);
		if (op == OP_FREE && g.st == STS_OK)
			freed_q.push_back(addr);
		pending_q.push_back('{pause: 1'b0, op: op, req: req, addr: addr});
		grant_q.push_back(g);
	endtask

	task automatic free_live(int idx);
		logic [19:0] a;
		a = live_q[idx];
		live_q.delete(idx);
		queue_request(OP_FREE, '0, a);
	endtask

	task automatic queue_pause();
		pending_q.push_back('{pause: 1'b1, op: OP_ALLOC, req: '0, addr: '0});
	endtask

	function automatic logic [REQ_W-1:0] random_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return REQ_W'($urandom_range(1, 256));
		else if (r < 95)
			return REQ_W'($urandom_range(257, 65536));
		return REQ_W'($urandom_range(65537, 2097151));
	endfunction

	function automatic int gap_length();
		if (no_gaps || $urandom_range(0, 3) == 0)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		n_fail++;
	endtask

	// request driver
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		heap_req_t it;
		logic      vld;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			vld = s_tvalid;
			if (s_tvalid && s_tready) begin
				n_sent <= n_sent + 1;
				vld = 1'b0;
				if ($urandom_range(0, 99) == 0)
					no_gaps <= ~no_gaps;
			end
			if (!vld) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else if (pending_q.size() > 0 && pending_q[0].pause) begin
					if (n_done == n_sent && !s_tvalid)
						void'(pending_q.pop_front());
				end else if (pending_q.size() > 0) begin
					it = pending_q.pop_front();
					s_tdata <= {7'($urandom), it.addr, it.req};
					s_tuser <= it.op;
					vld = 1'b1;
					gap_left <= gap_length();
				end
			end
			s_tvalid <= vld;
		end
	end

	// result monitor
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_done <= n_done + 1;
				if (grant_q.size() == 0) begin
					$display("[%0t] result with no request outstanding", $realtime);
					n_fail++;
				end else begin
					g = grant_q.pop_front();
					if (m_tdata[19:0] !== g.addr)
						report_mismatch("data_address", m_tdata[19:0], g.addr);
					if (m_tdata[39:20] !== g.len)
						report_mismatch("granted_bytes", m_tdata[39:20], g.len);
					if (m_tuser !== g.st)
						report_mismatch("status", m_tuser, g.st);
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left <= gap_length();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("first_fit_heap_allocator regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			sh_start[i] = '0;
			sh_len[i] = '0;
			sh_free[i] = 1'b0;
			sh_next[i] = MAX_BLOCKS;
			sh_prev[i] = MAX_BLOCKS;
			sh_spare[i] = i + 1;
		end
		sh_len[0] = LEN_W'(HEAP_BYTES - HDR_BYTES);
		sh_free[0] = 1'b1;
		sh_spare[0] = MAX_BLOCKS;
		spare_head = 1;

		// directed: null cases, no fit, whole heap, bad and double frees
		queue_request(OP_ALLOC, '0, '0);
		queue_request(OP_FREE, '0, '0);
		queue_request(OP_ALLOC, 21'd1048576, '0);
		queue_request(OP_ALLOC, 21'h1FFFFF, 20'hFFFFF);
		queue_request(OP_ALLOC, 21'd1048536, '0);
		queue_request(OP_ALLOC, 21'd1, '0);
		free_live(0);
		queue_request(OP_ALLOC, 21'd1, '0);
		queue_request(OP_ALLOC, 21'd9, '0);
		queue_request(OP_ALLOC, 21'd7, '0);
		queue_request(OP_FREE, '0, 20'd41);
		queue_request(OP_FREE, '0, 20'hFFFFF);
		queue_request(OP_FREE, '0, 20'h55555);
		queue_request(OP_FREE, '0, 20'hAAAAA);
		free_live(1);
		queue_request(OP_FREE, '0, freed_q[freed_q.size()-1]);
		free_live(0);
		queue_request(OP_ALLOC, 21'd1048488, '0);
		while (live_q.size() > 0)
			free_live(0);
		queue_request(OP_ALLOC, 21'd1048536, '0);
		free_live(0);
		queue_pause();

		// random mix of allocations, frees of live blocks and noise
		for (int i = 0; i < 400; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55 || live_q.size() == 0)
				queue_request(OP_ALLOC, random_size(), '0);
			else if (r < 93)
				free_live($urandom_range(0, live_q.size() - 1));
			else if (r < 96)
				queue_request(OP_FREE, '0, freed_q[$urandom_range(0, freed_q.size() - 1)]);
			else if (r < 98)
				queue_request(OP_FREE, 21'($urandom), 20'($urandom));
			else
				queue_request(OP_ALLOC, '0, 20'($urandom));
		end
		while (live_q.size() > 0)
			free_live($urandom_range(0, live_q.size() - 1));
		queue_pause();

		// fill the block table until allocations are granted unsplit
		for (int i = 0; i < 1030; i++)
			queue_request(OP_ALLOC, REQ_W'($urandom_range(1, 16)), '0);
		for (int i = 0; i < 30 && live_q.size() > 0; i++)
			free_live(live_q.size() > 4 && $urandom_range(0, 9) == 0 ? 1 : 0);

		#1 arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() == 0 && n_done == n_sent && !s_tvalid);
		repeat (3200) @(posedge clk);
		if (n_fail == 0 && grant_q.size() == 0)
			$display("first_fit_heap_allocator regression: pass");
		else
			$display("first_fit_heap_allocator regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_alu.sv
rtl/ffa_store.sv
rtl/ffa_ctrl.sv
rtl/first_fit_heap_allocator.sv
tb/tb.sv
